// ----- rtl/hte_pkg.sv -----
// Package: shared types, codes and lookup functions for the HTML text extractor.
`timescale 1ns / 1ps
package hte_pkg;

  localparam int QDepth  = 4;
  localparam int QAw     = 2;
  localparam int MaxList = 6;
  localparam int HoldLen = 5;

  // tag match node codes
  localparam logic [5:0] NodeNone       = 6'd0;
  localparam logic [5:0] NodeLimit      = 6'd32;
  localparam logic [5:0] GoBlock        = 6'd32;
  localparam logic [5:0] GoScriptOpen   = 6'd33;
  localparam logic [5:0] GoStyleOpen    = 6'd34;
  localparam logic [5:0] GoScriptClose  = 6'd35;
  localparam logic [5:0] GoStyleClose   = 6'd36;

  // one queue entry: bytes handed from the front to the back for one input item
  typedef struct packed {
    logic [MaxList-1:0][7:0] chars;
    logic [2:0]              count;
    logic                    pass;
    logic                    last;
  } entry_t;

  // tag name match transitions; returns NodeNone when no edge matches
  function automatic logic [5:0] edge_next(input logic [4:0] node, input logic [7:0] lc);
    logic [5:0] to;
    to = NodeNone;
    case (node)
      5'd1: begin
        case (lc)
          "s": to = 6'd2;
          "/": to = 6'd10;
          "p": to = GoBlock;
          "b": to = 6'd21;
          "d": to = 6'd22;
          "l": to = 6'd24;
          "h": to = 6'd25;
          "t": to = 6'd26;
          default: to = NodeNone;
        endcase
      end
      5'd2: begin
        if (lc == "c") to = 6'd3;
        else if (lc == "t") to = 6'd7;
      end
      5'd3:  if (lc == "r") to = 6'd4;
      5'd4:  if (lc == "i") to = 6'd5;
      5'd5:  if (lc == "p") to = 6'd6;
      5'd6:  if (lc == "t") to = GoScriptOpen;
      5'd7:  if (lc == "y") to = 6'd8;
      5'd8:  if (lc == "l") to = 6'd9;
      5'd9:  if (lc == "e") to = GoStyleOpen;
      5'd10: if (lc == "s") to = 6'd11;
      5'd11: begin
        if (lc == "c") to = 6'd12;
        else if (lc == "t") to = 6'd17;
      end
      5'd12: if (lc == "r") to = 6'd13;
      5'd13: if (lc == "i") to = 6'd14;
      5'd14: if (lc == "p") to = 6'd15;
      5'd15: if (lc == "t") to = 6'd16;
      5'd16: if (lc == ">") to = GoScriptClose;
      5'd17: if (lc == "y") to = 6'd18;
      5'd18: if (lc == "l") to = 6'd19;
      5'd19: if (lc == "e") to = 6'd20;
      5'd20: if (lc == ">") to = GoStyleClose;
      5'd21: if (lc == "r") to = GoBlock;
      5'd22: if (lc == "i") to = 6'd23;
      5'd23: if (lc == "v") to = GoBlock;
      5'd24: if (lc == "i") to = GoBlock;
      5'd25: if (lc >= "1" && lc <= "6") to = GoBlock;
      5'd26: if (lc == "r") to = GoBlock;
      default: to = NodeNone;
    endcase
    return to;
  endfunction

  // entity text, one character at a time
  function automatic logic [7:0] ent_char(input int e, input int i);
    logic [5:0][7:0] s;
    case (e)
      0: s = {8'h00, ";", "p", "m", "a", "&"};
      1: s = {8'h00, 8'h00, ";", "t", "l", "&"};
      2: s = {8'h00, 8'h00, ";", "t", "g", "&"};
      3: s = {";", "t", "o", "u", "q", "&"};
      4: s = {";", "p", "s", "b", "n", "&"};
      default: s = {";", "s", "o", "p", "a", "&"};
    endcase
    return s[i];
  endfunction

  function automatic logic [2:0] ent_len(input int e);
    case (e)
      0: return 3'd5;
      1: return 3'd4;
      2: return 3'd4;
      default: return 3'd6;
    endcase
  endfunction

  function automatic logic [7:0] ent_val(input int e);
    case (e)
      0: return "&";
      1: return "<";
      2: return ">";
      3: return 8'h22;
      4: return " ";
      default: return 8'h27;
    endcase
  endfunction

endpackage

// ----- rtl/hte_front.sv -----
// Front part: tag stripping, tag name matching and entity decoding per input byte.
`timescale 1ns / 1ps
module hte_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            end_of_doc,
  output logic            q_push,
  output hte_pkg::entry_t q_entry
);
  import hte_pkg::*;

  logic [2:0]        flags, flags_next;
  logic [4:0]        node, node_next;
  logic              saved, saved_next;
  logic [7:0]        hold [HoldLen];
  logic [7:0]        hold_next [HoldLen];
  logic [2:0]        cnt, cnt_next;

  logic [7:0]        lc;
  logic [5:0]        to;
  logic              matched;
  logic              ev_valid;
  logic [7:0]        ev_char;
  logic              ent_hit, ent_done;
  logic [7:0]        ent_v;
  logic              ok;
  logic [7:0]        part [MaxList];
  logic [2:0]        pn;
  logic [2:0]        j;
  entry_t            ent;

  // tag stripping and tag name match
  always_comb begin
    lc         = (in_byte >= "A" && in_byte <= "Z") ? in_byte + 8'd32 : in_byte;
    flags_next = flags;
    node_next  = node;
    saved_next = saved;
    ev_valid   = 1'b0;
    ev_char    = in_byte;
    matched    = 1'b0;
    to         = NodeNone;
    if (node != 5'd0) begin
      to = edge_next(node, lc);
      if (to != NodeNone) begin
        matched = 1'b1;
        if (to < NodeLimit) begin
          node_next = to[4:0];
        end else begin
          node_next = 5'd0;
          case (to)
            GoBlock: begin
              if (flags[2:1] == 2'b00) begin
                ev_valid = 1'b1;
                ev_char  = 8'h0a;
              end
            end
            GoScriptOpen: flags_next[1] = 1'b1;
            GoStyleOpen:  flags_next[2] = 1'b1;
            GoScriptClose: begin
              flags_next[1] = 1'b0;
              flags_next[0] = saved;
            end
            default: begin
              flags_next[2] = 1'b0;
              flags_next[0] = saved;
            end
          endcase
        end
      end else begin
        node_next = 5'd0;
      end
    end
    if (!matched) begin
      if (in_byte == "<") begin
        saved_next    = flags[0];
        flags_next[0] = 1'b1;
        node_next     = 5'd1;
      end else if (in_byte == ">") begin
        flags_next[0] = 1'b0;
      end else if (flags == 3'b000) begin
        ev_valid = 1'b1;
      end
    end
  end

  // entity match against the held prefix
  always_comb begin
    ent_hit  = 1'b0;
    ent_done = 1'b0;
    ent_v    = 8'h00;
    ok       = 1'b0;
    for (int e = 0; e < 6; e++) begin
      ok = (ent_len(e) >= cnt + 3'd1);
      for (int i = 0; i < MaxList; i++) begin
        if (i < int'(cnt)) ok = ok && (hold[i] == ent_char(e, i));
        if (i == int'(cnt)) ok = ok && (ev_char == ent_char(e, i));
      end
      if (ok && !ent_hit) begin
        ent_hit  = 1'b1;
        ent_done = (ent_len(e) == cnt + 3'd1);
        ent_v    = ent_val(e);
      end
    end
  end

  // build the byte list for this item
  always_comb begin
    for (int i = 0; i < HoldLen; i++) hold_next[i] = hold[i];
    for (int i = 0; i < MaxList; i++) part[i] = 8'h00;
    cnt_next = cnt;
    pn       = 3'd0;
    if (ev_valid) begin
      if (cnt == 3'd0) begin
        if (ev_char == "&") begin
          hold_next[0] = ev_char;
          cnt_next     = 3'd1;
        end else begin
          part[0] = ev_char;
          pn      = 3'd1;
        end
      end else if (ent_hit) begin
        if (ent_done) begin
          cnt_next = 3'd0;
          part[0]  = ent_v;
          pn       = 3'd1;
        end else begin
          for (int i = 0; i < HoldLen; i++)
            if (i == int'(cnt)) hold_next[i] = ev_char;
          cnt_next = cnt + 3'd1;
        end
      end else begin
        cnt_next = 3'd0;
        for (int i = 0; i < HoldLen; i++)
          if (i < int'(cnt)) part[i] = hold[i];
        pn = cnt;
        if (ev_char == "&") begin
          hold_next[0] = ev_char;
          cnt_next     = 3'd1;
        end else begin
          for (int i = 0; i < MaxList; i++)
            if (i == int'(cnt)) part[i] = ev_char;
          pn = cnt + 3'd1;
        end
      end
    end

    // flush a held partial entity at the end of the document
    ent.pass = 1'b0;
    ent.last = end_of_doc;
    ent.count = pn;
    j = 3'd0;
    for (int i = 0; i < MaxList; i++) begin
      j = 3'(i) - pn;
      if (i < int'(pn)) ent.chars[i] = part[i];
      else if (end_of_doc && j < cnt_next) ent.chars[i] = hold_next[j[2:0]];
      else ent.chars[i] = 8'h00;
    end
    if (end_of_doc) ent.count = pn + cnt_next;
    if (!mode) begin
      ent.chars    = '0;
      ent.chars[0] = in_byte;
      ent.count    = 3'd1;
      ent.pass     = 1'b1;
    end
  end

  assign q_entry = ent;
  assign q_push  = accept && (ent.count != 3'd0 || end_of_doc);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= 3'b000;
      node  <= 5'd0;
      saved <= 1'b0;
      cnt   <= 3'd0;
    end else if (accept) begin
      if (end_of_doc) begin
        flags <= 3'b000;
        node  <= 5'd0;
        saved <= 1'b0;
        cnt   <= 3'd0;
      end else if (mode) begin
        flags <= flags_next;
        node  <= node_next;
        saved <= saved_next;
        cnt   <= cnt_next;
      end
    end
  end

  // held entity bytes
  always_ff @(posedge clk) begin
    if (accept && mode) begin
      for (int i = 0; i < HoldLen; i++) hold[i] <= hold_next[i];
    end
  end

endmodule

// ----- rtl/hte_queue.sv -----
// Short queue of byte lists between the front and the back part.
`timescale 1ns / 1ps
module hte_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  hte_pkg::entry_t wdata,
  input  logic            rd,
  output hte_pkg::entry_t rdata,
  output logic            q_full,
  output logic            q_empty
);
  import hte_pkg::*;

  entry_t           slots [QDepth];
  logic [QAw-1:0]   wptr, rptr;
  logic [QAw:0]     level;

  assign q_full  = (level == (QAw+1)'(QDepth));
  assign q_empty = (level == '0);
  assign rdata   = slots[rptr];

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      if (wr && !rd) level <= level + 1'b1;
      else if (rd && !wr) level <= level - 1'b1;
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wdata;
  end

endmodule

// ----- rtl/hte_back.sv -----
// Back part: whitespace collapse, trim, sequencing; one byte per cycle unless stalled.
`timescale 1ns / 1ps
module hte_back (
  input  logic            clk,
  input  logic            rst,
  input  hte_pkg::entry_t head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic [7:0]      text_byte,
  output logic            byte_present,
  output logic            doc_done,
  output logic            empty,
  input  logic            pop
);
  import hte_pkg::*;

  logic [2:0] idx, idx_next;
  logic [1:0] run, run_next, run_c;
  logic       started, started_next;
  logic [7:0] pend [2];
  logic [7:0] pend_next [2];
  logic [1:0] pcnt, pcnt_next;
  logic [1:0] pptr, pptr_next;
  logic       lag_valid, lag_valid_next;
  logic [7:0] lag_byte, lag_byte_next;

  logic       out_valid;
  logic       ofree;
  logic       emit, fin, adv, need_slot, go;
  logic [7:0] eb, ch, tb;
  logic       tvalid;
  logic       load;
  logic [7:0] load_byte;
  logic       load_present, load_done;

  assign ofree = !out_valid || pop;
  assign empty = !out_valid;

  // collapse and trim one byte of the head entry
  always_comb begin
    ch     = head.chars[idx];
    emit   = 1'b0;
    fin    = 1'b0;
    adv    = 1'b0;
    eb     = ch;
    tb     = ch;
    tvalid = 1'b0;
    run_c  = run;
    run_next       = run;
    started_next   = started;
    pend_next[0]   = pend[0];
    pend_next[1]   = pend[1];
    pcnt_next      = pcnt;
    pptr_next      = pptr;
    if (!q_empty && idx < head.count) begin
      if (head.pass) begin
        emit = 1'b1;
        adv  = 1'b1;
      end else begin
        if (ch == 8'h0a || ch == 8'h0d) begin
          tvalid = !run[1];
          tb     = 8'h0a;
          run_c  = 2'b10;
        end else if (ch == " " || ch == 8'h09) begin
          tvalid = (run == 2'b00);
          tb     = " ";
          run_c  = tvalid ? (run | 2'b01) : run;
        end else begin
          tvalid = 1'b1;
          run_c  = 2'b00;
        end
        if (!tvalid) begin
          run_next = run_c;
          adv      = 1'b1;
        end else if (tb == " " || tb == 8'h0a) begin
          run_next = run_c;
          adv      = 1'b1;
          if (started && pcnt < 2'd2) begin
            pend_next[pcnt[0]] = tb;
            pcnt_next          = pcnt + 2'd1;
          end
        end else if (pptr < pcnt) begin
          emit      = 1'b1;
          eb        = pend[pptr[0]];
          pptr_next = pptr + 2'd1;
        end else begin
          emit         = 1'b1;
          eb           = tb;
          pcnt_next    = 2'd0;
          pptr_next    = 2'd0;
          started_next = 1'b1;
          run_next     = run_c;
          adv          = 1'b1;
        end
      end
    end else if (!q_empty) begin
      fin = 1'b1;
    end
  end

  // route results: direct, through the lag stage on a closing item, or the closing transfer
  always_comb begin
    need_slot      = 1'b0;
    load           = 1'b0;
    load_byte      = eb;
    load_present   = 1'b1;
    load_done      = 1'b0;
    lag_valid_next = lag_valid;
    lag_byte_next  = lag_byte;
    if (fin) begin
      need_slot    = 1'b1;
      load         = 1'b1;
      load_byte    = lag_valid ? lag_byte : 8'h00;
      load_present = lag_valid;
      load_done    = 1'b1;
      lag_valid_next = 1'b0;
    end else if (emit) begin
      if (head.last) begin
        lag_valid_next = 1'b1;
        lag_byte_next  = eb;
        if (lag_valid) begin
          need_slot = 1'b1;
          load      = 1'b1;
          load_byte = lag_byte;
        end
      end else begin
        need_slot = 1'b1;
        load      = 1'b1;
      end
    end
    go = !need_slot || ofree;
    idx_next = idx;
    q_pop    = 1'b0;
    if (go && fin) begin
      q_pop    = 1'b1;
      idx_next = 3'd0;
    end else if (go && adv) begin
      if (idx + 3'd1 == head.count && !head.last) begin
        q_pop    = 1'b1;
        idx_next = 3'd0;
      end else begin
        idx_next = idx + 3'd1;
      end
    end
  end

  // back control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      run       <= 2'b00;
      started   <= 1'b0;
      pcnt      <= 2'd0;
      pptr      <= 2'd0;
      lag_valid <= 1'b0;
    end else if (go) begin
      idx       <= idx_next;
      lag_valid <= lag_valid_next;
      if (fin) begin
        run     <= 2'b00;
        started <= 1'b0;
        pcnt    <= 2'd0;
        pptr    <= 2'd0;
      end else if (!head.pass) begin
        run     <= run_next;
        started <= started_next;
        pcnt    <= pcnt_next;
        pptr    <= pptr_next;
      end
    end
  end

  // held blanks and lag byte
  always_ff @(posedge clk) begin
    if (go) begin
      pend[0]  <= pend_next[0];
      pend[1]  <= pend_next[1];
      lag_byte <= lag_byte_next;
    end
  end

  // output register: load a result or drop the transferred one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && load) begin
      text_byte    <= load_byte;
      byte_present <= load_present;
      doc_done     <= load_done;
    end
  end

endmodule

// ----- rtl/html_markup_text_extractor.sv -----
// Top level: HTML markup to plain text extractor.
// Input channel: present in_byte/end_of_doc with push; a byte transfers when
// push is high and full is low. Result channel: while empty is low the oldest
// result sits on text_byte/byte_present/doc_done and transfers when pop is high.
// Configuration: cfg_write loads markup_mode (1 = strip markup, 0 = pass bytes
// unchanged); write it only while the block is idle. Reset sets it to 1.
// A front stage classifies one byte per cycle while full is low (tag match,
// entity decode) and queues up to six text bytes per input byte in a
// four-entry queue; the back stage collapses and trims whitespace and gives
// one result per cycle while the output is free. A byte passes the queue and
// the output register before it shows on the result port. Throughput: one
// input byte per cycle while each byte yields at most one result; the single
// result port sets the limit, so items with several results (flushed entities,
// held blanks) give them one at a time, and a document's last byte also needs
// a closing item. When pop stays low the output register holds, the back stalls,
// the queue fills and full rises. Synchronous reset clears all document state.
`timescale 1ns / 1ps
module html_markup_text_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       markup_mode,
  input  logic [7:0] in_byte,
  input  logic       end_of_doc,
  input  logic       push,
  output logic       full,
  output logic [7:0] text_byte,
  output logic       byte_present,
  output logic       doc_done,
  output logic       empty,
  input  logic       pop
);
  import hte_pkg::*;

  logic   mode;
  logic   accept;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_in, q_head;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg_write) begin
      mode <= markup_mode;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  hte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .accept     (accept),
    .in_byte    (in_byte),
    .end_of_doc (end_of_doc),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  hte_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wdata   (q_in),
    .rd      (q_pop),
    .rdata   (q_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  hte_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .text_byte    (text_byte),
    .byte_present (byte_present),
    .doc_done     (doc_done),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

// ----- bench/tb.sv -----
// Testbench for the HTML markup to plain text extractor: random and directed documents.
`timescale 1ns / 1ps
module tb;
  import hte_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       eod;
  } doc_byte_t;

  typedef struct packed {
    logic [7:0] b;
    logic       pr;
    logic       done;
  } text_item_t;

  localparam int StallLimit = 2000;
  localparam int LongHold   = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       markup_mode = 1'b1;
  logic [7:0] in_byte = 8'd0;
  logic       end_of_doc = 1'b0;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic       full, byte_present, doc_done, empty;
  logic [7:0] text_byte;

  html_markup_text_extractor DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .markup_mode(markup_mode),
    .in_byte(in_byte), .end_of_doc(end_of_doc), .push(push), .full(full),
    .text_byte(text_byte), .byte_present(byte_present), .doc_done(doc_done),
    .empty(empty), .pop(pop)
  );

  doc_byte_t  doc_feed[$];
  text_item_t text_expect[$];
  text_item_t step_out[$];
  int         mismatches = 0;
  int         steady = 0;
  int         hold_req = 0;

  // predictor state
  logic       mode_now = 1'b1;
  logic [2:0] in_flags;
  logic [5:0] tag_node;
  logic       saved_tag;
  logic [7:0] ent_hold[5];
  int         ent_cnt;
  logic [1:0] run_flags;
  logic       started;
  logic [7:0] blanks[2];
  int         blank_cnt;

  initial forever #1 clk = ~clk;

  function automatic void clear_doc();
    in_flags = 3'd0;
    tag_node = NodeNone;
    saved_tag = 1'b0;
    ent_cnt = 0;
    run_flags = 2'd0;
    started = 1'b0;
    blank_cnt = 0;
  endfunction

  function automatic string ent_text(int e);
    case (e)
      0: return "&amp;";
      1: return "&lt;";
      2: return "&gt;";
      3: return "&quot;";
      4: return "&nbsp;";
      default: return "&apos;";
    endcase
  endfunction

  function automatic logic [7:0] ent_value(int e);
    case (e)
      0: return "&";
      1: return "<";
      2: return ">";
      3: return 8'h22;
      4: return " ";
      default: return 8'h27;
    endcase
  endfunction

  // next tag name node after lowercase char lc, NodeNone when the match breaks
  function automatic logic [5:0] tag_next(logic [5:0] node, logic [7:0] lc);
    case ({node, lc})
      {6'd1, "s"}: return 6'd2;
      {6'd2, "c"}: return 6'd3;
      {6'd3, "r"}: return 6'd4;
      {6'd4, "i"}: return 6'd5;
      {6'd5, "p"}: return 6'd6;
      {6'd6, "t"}: return GoScriptOpen;
      {6'd2, "t"}: return 6'd7;
      {6'd7, "y"}: return 6'd8;
      {6'd8, "l"}: return 6'd9;
      {6'd9, "e"}: return GoStyleOpen;
      {6'd1, "/"}: return 6'd10;
      {6'd10, "s"}: return 6'd11;
      {6'd11, "c"}: return 6'd12;
      {6'd12, "r"}: return 6'd13;
      {6'd13, "i"}: return 6'd14;
      {6'd14, "p"}: return 6'd15;
      {6'd15, "t"}: return 6'd16;
      {6'd16, ">"}: return GoScriptClose;
      {6'd11, "t"}: return 6'd17;
      {6'd17, "y"}: return 6'd18;
      {6'd18, "l"}: return 6'd19;
      {6'd19, "e"}: return 6'd20;
      {6'd20, ">"}: return GoStyleClose;
      {6'd1, "p"}, {6'd21, "r"}, {6'd23, "v"}, {6'd24, "i"}, {6'd26, "r"}: return GoBlock;
      {6'd1, "b"}: return 6'd21;
      {6'd1, "d"}: return 6'd22;
      {6'd22, "i"}: return 6'd23;
      {6'd1, "l"}: return 6'd24;
      {6'd1, "h"}: return 6'd25;
      {6'd1, "t"}: return 6'd26;
      default: begin
        if (node == 6'd25 && lc >= "1" && lc <= "6") return GoBlock;
        return NodeNone;
      end
    endcase
  endfunction

  function automatic void emit(logic [7:0] b, logic pr);
    if (step_out.size() < 8) step_out.push_back({b, pr, 1'b0});
  endfunction

  // hold back blanks until text follows; drop leading ones
  function automatic void trim_put(logic [7:0] b);
    if (b == " " || b == "\n") begin
      if (started && blank_cnt < 2) begin
        blanks[blank_cnt] = b;
        blank_cnt++;
      end
      return;
    end
    started = 1'b1;
    for (int i = 0; i < blank_cnt; i++) emit(blanks[i], 1'b1);
    blank_cnt = 0;
    emit(b, 1'b1);
  endfunction

  function automatic void collapse_put(logic [7:0] b);
    if (b == "\n" || b == "\r") begin
      if (!run_flags[1]) begin
        trim_put("\n");
        run_flags[1] = 1'b1;
      end
      run_flags[0] = 1'b0;
    end else if (b == " " || b == "\t") begin
      if (run_flags == 2'd0) begin
        trim_put(" ");
        run_flags[0] = 1'b1;
      end
    end else begin
      trim_put(b);
      run_flags = 2'd0;
    end
  endfunction

  function automatic void entity_put(logic [7:0] c);
    string nm;
    bit    hit;
    int    k;
    k = ent_cnt;
    if (k == 0) begin
      if (c == "&") begin
        ent_hold[0] = c;
        ent_cnt = 1;
      end else collapse_put(c);
      return;
    end
    for (int e = 0; e < 6; e++) begin
      nm = ent_text(e);
      if (nm.len() >= k + 1) begin
        hit = (nm[k] == c);
        for (int i = 0; i < k; i++) if (nm[i] != ent_hold[i]) hit = 0;
        if (hit) begin
          if (nm.len() == k + 1) begin
            ent_cnt = 0;
            collapse_put(ent_value(e));
          end else begin
            ent_hold[k] = c;
            ent_cnt = k + 1;
          end
          return;
        end
      end
    end
    // unknown entity: release held bytes literally
    ent_cnt = 0;
    for (int i = 0; i < k; i++) collapse_put(ent_hold[i]);
    if (c == "&") begin
      ent_hold[0] = c;
      ent_cnt = 1;
    end else collapse_put(c);
  endfunction

  function automatic void strip_put(logic [7:0] c);
    logic [7:0] lc;
    logic [5:0] to;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (tag_node != NodeNone) begin
      to = tag_next(tag_node, lc);
      if (to != NodeNone) begin
        if (to < NodeLimit) tag_node = to;
        else begin
          tag_node = NodeNone;
          if (to == GoBlock) begin
            if (in_flags[2:1] == 2'd0) entity_put("\n");
          end else if (to == GoScriptOpen) in_flags[1] = 1'b1;
          else if (to == GoStyleOpen) in_flags[2] = 1'b1;
          else begin
            if (to == GoScriptClose) in_flags[1] = 1'b0;
            else in_flags[2] = 1'b0;
            in_flags[0] = saved_tag;
          end
        end
        return;
      end
      tag_node = NodeNone;
    end
    if (c == "<") begin
      saved_tag = in_flags[0];
      in_flags[0] = 1'b1;
      tag_node = 6'd1;
    end else if (c == ">") in_flags[0] = 1'b0;
    else if (in_flags == 3'd0) entity_put(c);
  endfunction

  function automatic void predict_text(logic [7:0] c, logic eod);
    int k;
    step_out.delete();
    if (!mode_now) emit(c, 1'b1);
    else begin
      strip_put(c);
      if (eod) begin
        k = ent_cnt;
        ent_cnt = 0;
        for (int i = 0; i < k; i++) collapse_put(ent_hold[i]);
      end
    end
    if (eod) begin
      if (step_out.size() == 0) emit(8'd0, 1'b0);
      step_out[step_out.size() - 1].done = 1'b1;
      clear_doc();
    end
    foreach (step_out[i]) text_expect.push_back(step_out[i]);
  endfunction

  // sender: transfer bytes from the feed with random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) push <= 1'b0;
    else begin
      if (push && !full) begin
        predict_text(in_byte, end_of_doc);
        void'(doc_feed.pop_front());
        send_gap = steady ? 0 : $urandom_range(0, 5);
        if (send_gap == 0 && doc_feed.size() > 0) begin
          push <= 1'b1;
          in_byte <= doc_feed[0].b;
          end_of_doc <= doc_feed[0].eod;
        end else push <= 1'b0;
      end else if (push) begin
        // hold the offered byte
      end else if (send_gap > 0) send_gap--;
      else if (doc_feed.size() > 0) begin
        push <= 1'b1;
        in_byte <= doc_feed[0].b;
        end_of_doc <= doc_feed[0].eod;
      end
    end
  end

  // receiver: check each transfer against the oldest expected text item
  int pop_gap = 0;
  int hold_left = 0;
  int hold_seen = 0;
  text_item_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (text_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %h present %b done %b",
                     text_byte, byte_present, doc_done);
        end else begin
          want = text_expect.pop_front();
          if (want != {text_byte, byte_present, doc_done}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected byte %h present %b done %b, got %h %b %b",
                       want.b, want.pr, want.done, text_byte, byte_present, doc_done);
          end
        end
        pop_gap = steady ? 0 : $urandom_range(0, 5);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else pop <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  int quiet = 0;
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet = 0;
    else quiet++;
    if (quiet >= StallLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic add_text(string s, bit eod_last);
    for (int i = 0; i < s.len(); i++)
      doc_feed.push_back({s[i], eod_last && (i == s.len() - 1)});
  endtask

  // wait until every result is in and the back has used up the queue
  task automatic drain();
    while (doc_feed.size() > 0 || push || text_expect.size() > 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    cfg_write <= 1'b1;
    markup_mode <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    mode_now = v;
    @(posedge clk);
  endtask

  function automatic string pick_frag(int k);
    case (k)
      0: return "<p>";        1: return "<BR>";      2: return "<div class=a>";
      3: return "<li>";       4: return "<h3>";      5: return "<TR>";
      6: return "<script>x<b>y</script>";            7: return "<style>p{}</style>";
      8: return "</p>";       9: return "<b>";       10: return "&amp;";
      11: return "&lt;";      12: return "&gt;";     13: return "&quot;";
      14: return "&nbsp;";    15: return "&apos;";   16: return "&am";
      17: return "&xyz;";     18: return "  ";       19: return "\t";
      20: return "\r\n";      21: return "\n\n";     22: return "Hello";
      23: return "a b";       24: return "<pre>";     25: return "<scr";
      26: return "</scrip>";  27: return "<<p";      default: return ">";
    endcase
  endfunction

  // one document of random fragments; ends with end_of_doc unless open
  task automatic add_random_doc(bit close_doc);
    logic [7:0] bytes[$];
    string      s;
    int         n;
    n = $urandom_range(1, 2);
    for (int f = 0; f < n; f++) begin
      if ($urandom_range(0, 9) == 0) bytes.push_back(8'($urandom_range(0, 255)));
      else begin
        s = pick_frag($urandom_range(0, 28));
        for (int i = 0; i < s.len(); i++) bytes.push_back(s[i]);
      end
    end
    foreach (bytes[i]) doc_feed.push_back({bytes[i], close_doc && (i == bytes.size() - 1)});
  endtask

  initial begin
    clear_doc();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, tag prefixes, closing tags, broken matches, entities
    add_text(" <H1>A&amp;B&x\t\r\n</sTyle>", 1'b0);
    doc_feed.push_back({8'hFF, 1'b0});
    doc_feed.push_back({8'h00, 1'b0});
    add_text("<scripts>q</SCRIPT>C&am", 1'b1);
    add_text("\n", 1'b1);
    add_text("<<p>&lt;&gt;&quot;&nbsp;&apos;&&amp; z  ", 1'b1);
    drain();

    // passthrough extreme
    write_mode(1'b0);
    doc_feed.push_back({8'h00, 1'b0});
    add_text("<p>&amp;", 1'b0);
    doc_feed.push_back({8'hFF, 1'b1});
    drain();
    write_mode(1'b1);

    // mode change in the middle of a document keeps its state
    add_text("x <b", 1'b0);
    drain();
    write_mode(1'b0);
    add_text(">y", 1'b0);
    drain();
    write_mode(1'b1);
    add_text(">z&am", 1'b1);
    drain();

    // fill the block while the receiver holds off
    steady = 1;
    hold_req++;
    add_text("fill the queue", 1'b1);
    add_random_doc(1'b1);
    drain();
    steady = 0;

    // random documents, one left open across a mode change
    for (int d = 0; d < 4; d++) begin
      if (d == 1) steady = 1;
      if (d == 2) steady = 0;
      add_random_doc(d != 2);
      if (d == 2) begin
        drain();
        write_mode(1'b0);
        add_random_doc(1'b0);
        drain();
        write_mode(1'b1);
      end
    end
    drain();

    if (mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hte_pkg.sv
rtl/hte_front.sv
rtl/hte_queue.sv
rtl/hte_back.sv
rtl/html_markup_text_extractor.sv
bench/tb.sv
